>>> rtl/mus_event_stream_parser_macros.svh
// ----------------------------------------------------------------------------
// MUS event stream parser - assertion macros
// Shared concurrent check forms, clocked on clk and held off while in reset.
// ----------------------------------------------------------------------------
`ifndef MUS_EVENT_STREAM_PARSER_MACROS_SVH
`define MUS_EVENT_STREAM_PARSER_MACROS_SVH

// Same-cycle implication.
`define MESP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MESP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mesp_pkg.sv
// ----------------------------------------------------------------------------
// MUS event stream parser - package
// Parse phases, event kinds, header type codes and the decoded event record.
// ----------------------------------------------------------------------------
`default_nettype none

package mesp_pkg;

    typedef enum logic [3:0] {
        PH_HEADER    = 4'd0,
        PH_RELEASE   = 4'd1,
        PH_PLAY_NOTE = 4'd2,
        PH_PLAY_VOL  = 4'd3,
        PH_BEND      = 4'd4,
        PH_SYSTEM    = 4'd5,
        PH_CTRL_NUM  = 4'd6,
        PH_CTRL_VAL  = 4'd7,
        PH_SKIP      = 4'd8,
        PH_DELAY     = 4'd9
    } mesp_phase_t;

    typedef enum logic [2:0] {
        K_RELEASE = 3'd0,
        K_PLAY    = 3'd1,
        K_BEND    = 3'd2,
        K_SYSTEM  = 3'd3,
        K_CTRL    = 3'd4,
        K_END     = 3'd5,
        K_UNKNOWN = 3'd6
    } mesp_kind_t;

    // Event type codes in bits 6..4 of a header byte
    localparam logic [2:0] TYPE_RELEASE = 3'd0;
    localparam logic [2:0] TYPE_PLAY    = 3'd1;
    localparam logic [2:0] TYPE_BEND    = 3'd2;
    localparam logic [2:0] TYPE_SYSTEM  = 3'd3;
    localparam logic [2:0] TYPE_CTRL    = 3'd4;
    localparam logic [2:0] TYPE_END     = 3'd6;

    localparam logic [6:0] VOLUME_DEFAULT = 7'd100;

    typedef struct packed {
        mesp_kind_t  event_kind;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [6:0]  volume;
        logic [6:0]  controller;
        logic [7:0]  value;
        logic        has_delay;
    } mesp_event_t;

endpackage

`default_nettype wire

>>> rtl/mus_event_stream_parser.sv
// ----------------------------------------------------------------------------
// MUS event stream parser - top level
// Byte-wide score input, one decoded event out per completed score event.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (byte_valid / byte_stall) carries data_byte and score_start.
//   A transfer takes place on a rising edge with valid high and stall low.
//   Raise score_start with the first header byte of a score: stored volumes
//   return to 100 and the parser restarts before that byte is decoded.
//   Output channel (event_valid / event_stall) carries one decoded event for
//   each score event, produced by its last byte (header, payload or delay).
//   The last byte of an event passes the input register, then parse logic
//   that loads the event register and sets event_valid.
//   Throughput: one byte per cycle while event_stall is low, for header,
//   payload and delay bytes alike.
//   While event_stall holds a waiting event, a byte in the input register is
//   held there and byte_stall stays high until the event is taken; with the
//   input register empty one more byte is still accepted.
//   Reset clears both valid flags and the parse state and sets all volumes
//   to 100.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mus_event_stream_parser_macros.svh"

module mus_event_stream_parser
    import mesp_pkg::*;
#(
    parameter int NUM_CHANNELS = 16,
    parameter int DELAY_BITS   = 28
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   byte_valid,
    output logic                        byte_stall,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   score_start,
    output logic                        event_valid,
    input  wire logic                   event_stall,
    output logic [2:0]                  event_kind,
    output logic [3:0]                  channel,
    output logic [6:0]                  note,
    output logic [6:0]                  volume,
    output logic [6:0]                  controller,
    output logic [7:0]                  value,
    output logic [DELAY_BITS-1:0]       delay_ticks,
    output logic                        has_delay
);

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_byte_reg;
    logic                   in_start_reg;
    logic                   out_valid_reg, out_valid_next;
    mesp_event_t            out_ev_reg;
    logic [DELAY_BITS-1:0]  out_delay_reg;

    logic                   out_free;
    logic                   take;
    logic                   emit;
    mesp_event_t            ev;
    logic [DELAY_BITS-1:0]  ev_delay;

    assign out_free   = !out_valid_reg || !event_stall;
    assign take       = in_valid_reg && out_free;
    assign byte_stall = in_valid_reg && !out_free;

    mesp_parse_core #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .DELAY_BITS   (DELAY_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .data_byte   (in_byte_reg),
        .score_start (in_start_reg),
        .emit        (emit),
        .ev          (ev),
        .delay_ticks (ev_delay)
    );

    always_comb
    begin
        in_valid_next  = byte_stall ? in_valid_reg : byte_valid;
        out_valid_next = out_free ? emit : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: input side loads on transfer, event side on emit; hold otherwise
    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            in_byte_reg  <= data_byte;
            in_start_reg <= score_start;
        end
        if (emit)
        begin
            out_ev_reg    <= ev;
            out_delay_reg <= ev_delay;
        end
    end

    assign event_valid = out_valid_reg;
    assign event_kind  = out_ev_reg.event_kind;
    assign channel     = out_ev_reg.channel;
    assign note        = out_ev_reg.note;
    assign volume      = out_ev_reg.volume;
    assign controller  = out_ev_reg.controller;
    assign value       = out_ev_reg.value;
    assign has_delay   = out_ev_reg.has_delay;
    assign delay_ticks = out_delay_reg;

    `MESP_ASSERT_IMP(a_emit_has_room, emit, out_free, "event produced with output slot full")
    `MESP_ASSERT_IMP(a_stall_from_output, byte_stall, out_valid_reg && event_stall, "input stalled without output back-pressure")
    `MESP_ASSERT_NXT(a_byte_held, in_valid_reg && !out_free, in_valid_reg && $stable(in_byte_reg), "held byte lost while output stalled")

endmodule

`default_nettype wire

>>> rtl/mesp_parse_core.sv
// ----------------------------------------------------------------------------
// MUS event stream parser - parse core
// Per-byte parse state, per-channel volume table and decoded event build.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mus_event_stream_parser_macros.svh"

module mesp_parse_core
    import mesp_pkg::*;
#(
    parameter int NUM_CHANNELS = 16,
    parameter int DELAY_BITS   = 28
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  take,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  score_start,
    output logic                       emit,
    output mesp_event_t                ev,
    output logic [DELAY_BITS-1:0]      delay_ticks
);

    localparam int ChW = $clog2(NUM_CHANNELS);
    localparam logic [DELAY_BITS-1:0] DelayMax = {DELAY_BITS{1'b1}};

    mesp_phase_t             phase_reg, phase_next, phase_eff;
    mesp_kind_t              kind_reg, kind_next;
    logic [3:0]              chan_reg, chan_next;
    logic                    flag_reg, flag_next;
    logic [6:0]              note_reg, note_next;
    logic [6:0]              ctrl_reg, ctrl_next;
    logic [7:0]              value_reg, value_next;
    logic [DELAY_BITS-1:0]   accum_reg, accum_next;
    logic [6:0]              vol_reg [NUM_CHANNELS];

    logic                    emit_raw;
    logic                    finish;
    logic                    vol_wr;
    logic                    delay_sat;
    logic [DELAY_BITS+6:0]   delay_ext;
    logic [6:0]              vol_src;

    assign delay_sat = |accum_reg[DELAY_BITS-1 -: 7];
    assign delay_ext = {accum_reg, data_byte[6:0]};

    always_comb
    begin
        phase_eff  = score_start ? PH_HEADER : phase_reg;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        chan_next  = chan_reg;
        flag_next  = flag_reg;
        note_next  = note_reg;
        ctrl_next  = ctrl_reg;
        value_next = value_reg;
        accum_next = accum_reg;
        emit_raw   = 1'b0;
        finish     = 1'b0;
        vol_wr     = 1'b0;

        case (phase_eff)
            PH_HEADER:
            begin
                chan_next  = data_byte[3:0];
                flag_next  = data_byte[7];
                note_next  = '0;
                ctrl_next  = '0;
                value_next = '0;
                accum_next = '0;
                case (data_byte[6:4])
                    TYPE_RELEASE:
                    begin
                        kind_next  = K_RELEASE;
                        phase_next = PH_RELEASE;
                    end
                    TYPE_PLAY:
                    begin
                        kind_next  = K_PLAY;
                        phase_next = PH_PLAY_NOTE;
                    end
                    TYPE_BEND:
                    begin
                        kind_next  = K_BEND;
                        phase_next = PH_BEND;
                    end
                    TYPE_SYSTEM:
                    begin
                        kind_next  = K_SYSTEM;
                        phase_next = PH_SYSTEM;
                    end
                    TYPE_CTRL:
                    begin
                        kind_next  = K_CTRL;
                        phase_next = PH_CTRL_NUM;
                    end
                    TYPE_END:
                    begin
                        // no payload and no delay bytes, even with the delay bit set
                        kind_next  = K_END;
                        phase_next = PH_HEADER;
                        emit_raw   = 1'b1;
                    end
                    default:
                    begin
                        kind_next  = K_UNKNOWN;
                        phase_next = PH_SKIP;
                    end
                endcase
            end
            PH_RELEASE:
            begin
                note_next = data_byte[6:0];
                finish    = 1'b1;
            end
            PH_PLAY_NOTE:
            begin
                note_next = data_byte[6:0];
                if (data_byte[7])
                begin
                    phase_next = PH_PLAY_VOL;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            PH_PLAY_VOL:
            begin
                vol_wr = 1'b1;
                finish = 1'b1;
            end
            PH_BEND:
            begin
                value_next = data_byte;
                finish     = 1'b1;
            end
            PH_SYSTEM, PH_CTRL_VAL:
            begin
                value_next = {1'b0, data_byte[6:0]};
                finish     = 1'b1;
            end
            PH_CTRL_NUM:
            begin
                ctrl_next  = data_byte[6:0];
                phase_next = PH_CTRL_VAL;
            end
            PH_SKIP:
            begin
                finish = 1'b1;
            end
            PH_DELAY:
            begin
                // saturate once another digit would overflow the accumulator
                accum_next = delay_sat ? DelayMax : delay_ext[DELAY_BITS-1:0];
                if (!data_byte[7])
                begin
                    emit_raw   = 1'b1;
                    phase_next = PH_HEADER;
                end
            end
            default:
            begin
                phase_next = PH_HEADER;
                kind_next  = K_RELEASE;
                chan_next  = '0;
                flag_next  = 1'b0;
                note_next  = '0;
                ctrl_next  = '0;
                value_next = '0;
                accum_next = '0;
            end
        endcase

        if (finish)
        begin
            if (flag_next)
            begin
                accum_next = '0;
                phase_next = PH_DELAY;
            end
            else
            begin
                emit_raw   = 1'b1;
                phase_next = PH_HEADER;
            end
        end
    end

    // A new volume byte is used by the event that carries it
    assign vol_src = (phase_eff == PH_PLAY_VOL) ? data_byte[6:0]
                                                : vol_reg[chan_next[ChW-1:0]];

    always_comb
    begin
        ev.event_kind = kind_next;
        ev.channel    = chan_next;
        ev.note       = (kind_next == K_RELEASE || kind_next == K_PLAY) ? note_next : '0;
        ev.volume     = (kind_next == K_PLAY) ? vol_src : '0;
        ev.controller = (kind_next == K_CTRL) ? ctrl_next : '0;
        ev.value      = (kind_next == K_BEND || kind_next == K_SYSTEM || kind_next == K_CTRL)
                        ? value_next : '0;
        ev.has_delay  = flag_next;
        delay_ticks   = (flag_next && kind_next != K_END) ? accum_next : '0;
    end

    assign emit = take && emit_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            kind_reg  <= K_RELEASE;
            chan_reg  <= '0;
            flag_reg  <= 1'b0;
            note_reg  <= '0;
            ctrl_reg  <= '0;
            value_reg <= '0;
            accum_reg <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            chan_reg  <= chan_next;
            flag_reg  <= flag_next;
            note_reg  <= note_next;
            ctrl_reg  <= ctrl_next;
            value_reg <= value_next;
            accum_reg <= accum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                vol_reg[i] <= VOLUME_DEFAULT;
            end
        end
        else if (take && score_start)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                vol_reg[i] <= VOLUME_DEFAULT;
            end
        end
        else if (take && vol_wr)
        begin
            vol_reg[chan_reg[ChW-1:0]] <= data_byte[6:0];
        end
    end

    `MESP_ASSERT_IMP(a_delay_needs_flag, phase_reg == PH_DELAY, flag_reg, "delay phase without delay flag")
    `MESP_ASSERT_IMP(a_volume_only_play, emit && ev.event_kind != K_PLAY, ev.volume == 7'd0, "volume on non-play event")
    `MESP_ASSERT_NXT(a_start_is_header, take && score_start, phase_reg != PH_DELAY && phase_reg != PH_PLAY_VOL && phase_reg != PH_CTRL_VAL, "score start did not restart at a header")

endmodule

`default_nettype wire

>>> sim/mus_event_stream_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MUS event stream parser - testbench
// Feeds score byte streams with random gaps, well-formed events, broken events
// and noise. Decodes each accepted byte in a local parser copy and checks the
// decoded events in order against the block, with random output stalls.
// ----------------------------------------------------------------------------
module mus_event_stream_parser_tb;
    import mesp_pkg::*;

    localparam int               DLY_W        = 28;
    localparam logic [DLY_W-1:0] DELAY_SAT    = {DLY_W{1'b1}};
    localparam logic [2:0]       TYPE_SKIP_A  = 3'd5;
    localparam logic [2:0]       TYPE_SKIP_B  = 3'd7;
    localparam int               RANDOM_BYTES = 850;
    localparam int               CYCLE_LIMIT  = 200000;
    localparam int               DRAIN_CYCLES = 8;
    localparam int               MAX_REPORTS  = 10;

    typedef struct {
        logic [7:0] data;
        logic       start;
        int         gap;
    } score_byte_t;

    typedef struct {
        mesp_kind_t       kind;
        logic [3:0]       chan;
        logic [6:0]       note;
        logic [6:0]       vol;
        logic [6:0]       ctl;
        logic [7:0]       val;
        logic [DLY_W-1:0] ticks;
        logic             has_dly;
    } decoded_event_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             byte_valid  = 1'b0;
    logic             byte_stall;
    logic [7:0]       data_byte   = 8'h00;
    logic             score_start = 1'b0;
    logic             event_valid;
    logic             event_stall = 1'b0;
    logic [2:0]       event_kind;
    logic [3:0]       channel;
    logic [6:0]       note;
    logic [6:0]       volume;
    logic [6:0]       controller;
    logic [7:0]       value;
    logic [DLY_W-1:0] delay_ticks;
    logic             has_delay;

    mus_event_stream_parser u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .data_byte   (data_byte),
        .score_start (score_start),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_kind  (event_kind),
        .channel     (channel),
        .note        (note),
        .volume      (volume),
        .controller  (controller),
        .value       (value),
        .delay_ticks (delay_ticks),
        .has_delay   (has_delay)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Parser copy and expected events
    // ------------------------------------------------------------------------
    mesp_phase_t      phase;
    mesp_kind_t       pend_kind;
    logic [3:0]       pend_chan;
    logic             pend_dly;
    logic [6:0]       note_hold;
    logic [6:0]       ctl_hold;
    logic [7:0]       val_hold;
    logic [DLY_W-1:0] dly_acc;
    logic [6:0]       chan_volume [16];
    decoded_event_t   expected_events [$];

    task automatic restart_parser();
        phase     = PH_HEADER;
        pend_kind = K_RELEASE;
        pend_chan = '0;
        pend_dly  = 1'b0;
        note_hold = '0;
        ctl_hold  = '0;
        val_hold  = '0;
        dly_acc   = '0;
        for (int i = 0; i < 16; i++)
            chan_volume[i] = VOLUME_DEFAULT;
    endtask

    task automatic post_event();
        decoded_event_t ev;
        ev.kind    = pend_kind;
        ev.chan    = pend_chan;
        ev.note    = (pend_kind == K_RELEASE || pend_kind == K_PLAY) ? note_hold : 7'd0;
        ev.vol     = (pend_kind == K_PLAY) ? chan_volume[pend_chan] : 7'd0;
        ev.ctl     = (pend_kind == K_CTRL) ? ctl_hold : 7'd0;
        ev.val     = (pend_kind == K_BEND || pend_kind == K_SYSTEM || pend_kind == K_CTRL)
                     ? val_hold : 8'd0;
        ev.ticks   = (pend_dly && pend_kind != K_END) ? dly_acc : '0;
        ev.has_dly = pend_dly;
        expected_events.push_back(ev);
        phase = PH_HEADER;
    endtask

    task automatic close_payload();
        if (pend_dly)
        begin
            dly_acc = '0;
            phase   = PH_DELAY;
        end
        else
            post_event();
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic start);
        if (start)
            restart_parser();
        case (phase)
            PH_HEADER:
            begin
                pend_chan = b[3:0];
                pend_dly  = b[7];
                note_hold = '0;
                ctl_hold  = '0;
                val_hold  = '0;
                dly_acc   = '0;
                case (b[6:4])
                    TYPE_RELEASE: begin pend_kind = K_RELEASE; phase = PH_RELEASE;   end
                    TYPE_PLAY:    begin pend_kind = K_PLAY;    phase = PH_PLAY_NOTE; end
                    TYPE_BEND:    begin pend_kind = K_BEND;    phase = PH_BEND;      end
                    TYPE_SYSTEM:  begin pend_kind = K_SYSTEM;  phase = PH_SYSTEM;    end
                    TYPE_CTRL:    begin pend_kind = K_CTRL;    phase = PH_CTRL_NUM;  end
                    TYPE_END:
                    begin
                        pend_kind = K_END;
                        post_event();
                    end
                    default:      begin pend_kind = K_UNKNOWN; phase = PH_SKIP;      end
                endcase
            end
            PH_RELEASE:
            begin
                note_hold = b[6:0];
                close_payload();
            end
            PH_PLAY_NOTE:
            begin
                note_hold = b[6:0];
                if (b[7])
                    phase = PH_PLAY_VOL;
                else
                    close_payload();
            end
            PH_PLAY_VOL:
            begin
                chan_volume[pend_chan] = b[6:0];
                close_payload();
            end
            PH_BEND:
            begin
                val_hold = b;
                close_payload();
            end
            PH_SYSTEM, PH_CTRL_VAL:
            begin
                val_hold = {1'b0, b[6:0]};
                close_payload();
            end
            PH_CTRL_NUM:
            begin
                ctl_hold = b[6:0];
                phase    = PH_CTRL_VAL;
            end
            PH_SKIP:
                close_payload();
            PH_DELAY:
            begin
                // stick at the ceiling once another 7 bits would overflow
                if (dly_acc > (DELAY_SAT >> 7))
                    dly_acc = DELAY_SAT;
                else
                    dly_acc = {dly_acc[DLY_W-8:0], b[6:0]};
                if (!b[7])
                    post_event();
            end
            default:
                phase = PH_HEADER;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus build
    // ------------------------------------------------------------------------
    score_byte_t byte_q [$];
    int          bytes_queued = 0;
    bit          calm_tx      = 1'b0;
    bit          resync       = 1'b0;

    task automatic queue_byte(input logic [7:0] b, input logic start);
        score_byte_t it;
        it.data  = b;
        it.start = start;
        it.gap   = calm_tx ? 0 : $urandom_range(0, 15);
        byte_q.push_back(it);
        bytes_queued++;
    endtask

    // One score event with random content; cut drops its tail
    task automatic queue_event(input bit cut);
        logic [7:0] seq [$];
        logic [2:0] ty;
        logic [3:0] ch;
        logic       dly;
        logic [7:0] nb;
        int         n_dly;
        int         keep;
        int         pick;
        ty  = 3'($urandom_range(0, 7));
        ch  = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
        dly = 1'($urandom_range(0, 1));
        seq.push_back({dly, ty, ch});
        case (ty)
            TYPE_END: ;
            TYPE_CTRL:
            begin
                seq.push_back(8'($urandom_range(0, 255)));
                seq.push_back(8'($urandom_range(0, 255)));
            end
            TYPE_PLAY:
            begin
                nb = 8'($urandom_range(0, 255));
                seq.push_back(nb);
                if (nb[7])
                    seq.push_back(8'($urandom_range(0, 255)));
            end
            default:
                seq.push_back(8'($urandom_range(0, 255)));
        endcase
        if (dly && ty != TYPE_END)
        begin
            pick  = $urandom_range(0, 9);
            n_dly = (pick < 6) ? 1 : (pick < 8) ? $urandom_range(2, 3) : $urandom_range(4, 7);
            for (int i = 0; i < n_dly; i++)
                seq.push_back({i != n_dly - 1, 7'($urandom_range(0, 127))});
        end
        keep = seq.size();
        if (cut && keep > 1)
            keep = $urandom_range(1, keep - 1);
        for (int i = 0; i < keep; i++)
            queue_byte(seq[i], (i == 0) && (resync || $urandom_range(0, 15) == 0));
        resync = cut;
    endtask

    // ------------------------------------------------------------------------
    // Byte driver
    // ------------------------------------------------------------------------
    score_byte_t staged_byte;
    bit          staged     = 1'b0;
    int          wait_left  = 0;
    logic        drive_valid;
    int          bytes_sent = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid  <= 1'b0;
            data_byte   <= 8'h00;
            score_start <= 1'b0;
            staged      = 1'b0;
            wait_left   = 0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                decode_byte(data_byte, score_start);
                bytes_sent++;
            end
            // hold a stalled transfer as it stands
            drive_valid = byte_valid && byte_stall;
            if (!drive_valid)
            begin
                if (!staged && byte_q.size() > 0)
                begin
                    staged_byte = byte_q.pop_front();
                    staged      = 1'b1;
                    wait_left   = staged_byte.gap;
                end
                if (staged)
                begin
                    if (wait_left == 0)
                    begin
                        data_byte   <= staged_byte.data;
                        score_start <= staged_byte.start;
                        drive_valid = 1'b1;
                        staged      = 1'b0;
                    end
                    else
                        wait_left--;
                end
            end
            byte_valid <= drive_valid;
        end
    end

    // ------------------------------------------------------------------------
    // Event monitor
    // ------------------------------------------------------------------------
    decoded_event_t want;
    int             stall_left  = 0;
    bit             calm_rx     = 1'b0;
    int             events_seen = 0;
    int             mismatches  = 0;
    int             kind_count [8];

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_stall <= 1'b0;
            stall_left  = 0;
        end
        else
        begin
            if (event_valid && !event_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("tb: unexpected event kind=%0d channel=%0d",
                                 event_kind, channel);
                    mismatches++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (event_kind !== want.kind || channel !== want.chan ||
                        note !== want.note || volume !== want.vol ||
                        controller !== want.ctl || value !== want.val ||
                        delay_ticks !== want.ticks || has_delay !== want.has_dly)
                    begin
                        if (mismatches < MAX_REPORTS)
                        begin
                            $display("tb: event %0d expected kind=%0d ch=%0d note=%0d vol=%0d ctl=%0d val=%0d ticks=%0d dly=%0d",
                                     events_seen, want.kind, want.chan, want.note, want.vol,
                                     want.ctl, want.val, want.ticks, want.has_dly);
                            $display("tb: event %0d actual   kind=%0d ch=%0d note=%0d vol=%0d ctl=%0d val=%0d ticks=%0d dly=%0d",
                                     events_seen, event_kind, channel, note, volume,
                                     controller, value, delay_ticks, has_delay);
                        end
                        mismatches++;
                    end
                end
                kind_count[event_kind]++;
                events_seen++;
                calm_rx    = ((events_seen / 32) % 4) == 2;
                stall_left = calm_rx ? 0 : $urandom_range(0, 15);
            end
            if (stall_left > 0)
            begin
                event_stall <= 1'b1;
                stall_left--;
            end
            else
                event_stall <= 1'b0;
        end
    end

    int cycles = 0;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    int pick;
    int n_noise;

    initial
    begin
        restart_parser();
        for (int i = 0; i < 8; i++)
            kind_count[i] = 0;

        // release, top note bit dropped, channel 0, with score start
        queue_byte({1'b0, TYPE_RELEASE, 4'h0}, 1'b1);
        queue_byte(8'hFF, 1'b0);
        // play on channel 15 with new full-scale volume and a one-byte zero delay
        queue_byte({1'b1, TYPE_PLAY, 4'hF}, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        // play on channel 15 again: remembered volume
        queue_byte({1'b0, TYPE_PLAY, 4'hF}, 1'b0);
        queue_byte(8'h7F, 1'b0);
        // play on untouched channel: default volume
        queue_byte({1'b0, TYPE_PLAY, 4'h3}, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte({1'b0, TYPE_BEND, 4'h1}, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte({1'b0, TYPE_SYSTEM, 4'h2}, 1'b0);
        queue_byte(8'hFF, 1'b0);
        // controller, top bits dropped, two-byte delay
        queue_byte({1'b1, TYPE_CTRL, 4'h4}, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h81, 1'b0);
        queue_byte(8'h00, 1'b0);
        // unknown type, skipped byte, delay that overflows and saturates
        queue_byte({1'b1, TYPE_SKIP_B, 4'h7}, 1'b0);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h81, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h00, 1'b0);
        // score end with delay flag set, then plain score end
        queue_byte({1'b1, TYPE_END, 4'h0}, 1'b0);
        queue_byte({1'b0, TYPE_END, 4'hF}, 1'b0);
        queue_byte({1'b0, TYPE_SKIP_A, 4'h5}, 1'b0);
        queue_byte(8'h00, 1'b0);

        while (bytes_queued < RANDOM_BYTES + 30)
        begin
            calm_tx = ((bytes_queued / 64) % 4) == 3;
            pick    = $urandom_range(0, 19);
            if (pick == 0)
            begin
                // noise: stray bytes, then restart the score
                n_noise = $urandom_range(1, 4);
                for (int i = 0; i < n_noise; i++)
                    queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                resync = 1'b1;
            end
            else
                queue_event(pick == 1);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_q.size() != 0 || staged || byte_valid)
            @(posedge clk);
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        mismatches += expected_events.size();
        $display("tb: %0d score bytes sent, %0d events checked, %0d mismatches",
                 bytes_sent, events_seen, mismatches);
        $display("tb: rel %0d play %0d bend %0d sys %0d ctl %0d end %0d skip %0d",
                 kind_count[K_RELEASE], kind_count[K_PLAY], kind_count[K_BEND],
                 kind_count[K_SYSTEM], kind_count[K_CTRL], kind_count[K_END],
                 kind_count[K_UNKNOWN]);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
